>>> rtl/core/cbss_pkg.sv
`timescale 1ns / 1ps
// Package for the cartridge bank select sequencer: field widths, mapper and
// status codes, adapter addresses and the write script types.
// No dependencies.
package cbss_pkg;

	localparam int BANK_W     = 9;
	localparam int ADDR_W     = 16;
	localparam int BYTE_W     = 8;
	localparam int STATUS_W   = 2;
	localparam int MK_W       = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam int SCRIPT_LEN = 6;
	localparam int COUNT_W    = 3;
	localparam int IDX_W      = 3;

	localparam logic [MK_W-1:0] MK_ROM_ONLY = 4'd0;
	localparam logic [MK_W-1:0] MK_MBC1     = 4'd1;
	localparam logic [MK_W-1:0] MK_MBC2     = 4'd2;
	localparam logic [MK_W-1:0] MK_MBC3     = 4'd3;
	localparam logic [MK_W-1:0] MK_MBC4     = 4'd4;
	localparam logic [MK_W-1:0] MK_MBC5     = 4'd5;
	localparam logic [MK_W-1:0] MK_MMM01    = 4'd6;
	localparam logic [MK_W-1:0] MK_CAMERA   = 4'd7;
	localparam logic [MK_W-1:0] MK_HUC1     = 4'd8;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNADDR = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MAPPER_KIND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_PRESENT = 2'd1;

	localparam logic [ADDR_W-1:0] ADDR_CTRL    = 16'hA00C;
	localparam logic [ADDR_W-1:0] ADDR_BANK_LO = 16'hE100;
	localparam logic [ADDR_W-1:0] ADDR_MODE    = 16'hE016;
	localparam logic [ADDR_W-1:0] ADDR_BANK_HI = 16'hC000;
	localparam logic [ADDR_W-1:0] ADDR_RAM_SEL = 16'hE000;

	localparam logic [BYTE_W-1:0] BYTE_OFF    = 8'h00;
	localparam logic [BYTE_W-1:0] BYTE_ON     = 8'h01;
	localparam logic [BYTE_W-1:0] BYTE_RAM_EN = 8'h0A;

	typedef enum logic [2:0] {
		SEQ_SINGLE    = 3'd0,
		SEQ_LOW       = 3'd1,
		SEQ_HIGH_LOW  = 3'd2,
		SEQ_RAM_FULL  = 3'd3,
		SEQ_RAM_SHORT = 3'd4,
		SEQ_REJECT    = 3'd5
	} seq_kind_t;

	typedef struct packed {
		logic              mode;
		logic [BANK_W-1:0] bank_number;
	} req_t;

	typedef struct packed {
		logic              write_valid;
		logic [ADDR_W-1:0] pak_address;
		logic [BYTE_W-1:0] write_byte;
	} entry_t;

	typedef struct packed {
		logic [STATUS_W-1:0]          status;
		logic [COUNT_W-1:0]           count;
		entry_t [SCRIPT_LEN-1:0]      entry;
	} script_t;

	function automatic entry_t wr(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] data);
		entry_t e;
		e.write_valid = 1'b1;
		e.pak_address = addr;
		e.write_byte  = data;
		return e;
	endfunction

endpackage

>>> rtl/core/cbss_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the bank select sequencer: request, result and
// configuration write. Depends on cbss_pkg.
interface cbss_req_if;
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [cbss_pkg::BANK_W-1:0] bank_number;
	modport source (output valid, output mode, output bank_number, input ready);
	modport sink (input valid, input mode, input bank_number, output ready);
endinterface

interface cbss_res_if;
	logic                          valid;
	logic                          ready;
	logic                          write_valid;
	logic [cbss_pkg::ADDR_W-1:0]   pak_address;
	logic [cbss_pkg::BYTE_W-1:0]   write_byte;
	logic                          last;
	logic [cbss_pkg::STATUS_W-1:0] status;
	modport source (output valid, output write_valid, output pak_address, output write_byte,
		output last, output status, input ready);
	modport sink (input valid, input write_valid, input pak_address, input write_byte,
		input last, input status, output ready);
endinterface

interface cbss_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [cbss_pkg::CFG_IDX_W-1:0]  index;
	logic [cbss_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/cbss_decode.sv
`timescale 1ns / 1ps
// Request register and decoder: turns a registered bank select request into
// the script of adapter writes for the configured mapper. Depends on cbss_pkg, cbss_if.
module cbss_decode (
	input  logic                        clk,
	input  logic                        arst_n,
	cbss_req_if.sink                    req,
	input  logic [cbss_pkg::MK_W-1:0]   mapper_kind,
	input  logic                        ram_present,
	output logic                        script_valid,
	output cbss_pkg::script_t           script,
	input  logic                        script_take
);
	import cbss_pkg::*;

	logic              valid_s1;
	req_t              req_s1;
	seq_kind_t         kind;
	logic [STATUS_W-1:0] rej;
	logic [BYTE_W-1:0] low;
	logic [BYTE_W-1:0] upper;
	logic [BANK_W-1:0] b;
	logic              ram_full;

	assign req.ready    = !valid_s1 || script_take;
	assign script_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.mode        <= req.mode;
			req_s1.bank_number <= req.bank_number;
		end
	end

	always_comb begin
		b     = req_s1.bank_number;
		kind  = SEQ_REJECT;
		rej   = ST_RANGE;
		low   = b[BYTE_W-1:0];
		upper = BYTE_ON;
		ram_full = ((mapper_kind == MK_MBC1 || mapper_kind == MK_MBC3 ||
			mapper_kind == MK_HUC1) && b <= 9'h003) ||
			((mapper_kind == MK_MBC4 || mapper_kind == MK_MBC5 ||
			mapper_kind == MK_CAMERA) && b <= 9'h00F);
		if (!req_s1.mode) begin
			if (mapper_kind == MK_ROM_ONLY || b == 9'h000) begin
				kind = SEQ_SINGLE;
			end else if (mapper_kind == MK_MBC1 || mapper_kind == MK_HUC1) begin
				if (b == 9'h020 || b == 9'h040 || b == 9'h060) begin
					rej = ST_UNADDR;
				end else if (b > 9'h07F) begin
					kind = SEQ_REJECT;
				end else if (b > 9'h020) begin
					kind  = SEQ_HIGH_LOW;
					upper = {6'd0, b[6:5]};
					low   = {3'd0, b[4:0]};
				end else begin
					kind = SEQ_LOW;
				end
			end else if (mapper_kind == MK_MBC2 && b <= 9'h00F) begin
				kind = SEQ_LOW;
			end else if (mapper_kind == MK_MBC3 && b <= 9'h07F) begin
				kind = SEQ_LOW;
			end else if (mapper_kind == MK_CAMERA && b <= 9'h03F) begin
				kind = SEQ_LOW;
			end else if (mapper_kind == MK_MBC4 || mapper_kind == MK_MBC5) begin
				if (b > 9'h0FF) begin
					kind = SEQ_HIGH_LOW;
				end else begin
					kind = SEQ_LOW;
				end
			end
		end else begin
			if (!ram_present || mapper_kind == MK_ROM_ONLY) begin
				kind = SEQ_REJECT;
			end else if (ram_full) begin
				kind = SEQ_RAM_FULL;
			end else if (mapper_kind == MK_MBC2) begin
				kind = SEQ_RAM_SHORT;
			end
		end

		script.status = ST_OK;
		script.count  = 3'd1;
		script.entry  = '0;
		case (kind)
			SEQ_SINGLE: begin
				script.entry[0] = wr(ADDR_CTRL, b[BYTE_W-1:0]);
			end
			SEQ_LOW: begin
				script.count    = 3'd3;
				script.entry[0] = wr(ADDR_CTRL, BYTE_OFF);
				script.entry[1] = wr(ADDR_BANK_LO, low);
				script.entry[2] = wr(ADDR_CTRL, BYTE_ON);
			end
			SEQ_HIGH_LOW: begin
				script.count    = 3'd6;
				script.entry[0] = wr(ADDR_CTRL, BYTE_ON);
				script.entry[1] = wr(ADDR_MODE, BYTE_OFF);
				script.entry[2] = wr(ADDR_BANK_HI, upper);
				script.entry[3] = wr(ADDR_CTRL, BYTE_OFF);
				script.entry[4] = wr(ADDR_BANK_LO, low);
				script.entry[5] = wr(ADDR_CTRL, BYTE_ON);
			end
			SEQ_RAM_FULL: begin
				script.count    = 3'd5;
				script.entry[0] = wr(ADDR_CTRL, BYTE_OFF);
				script.entry[1] = wr(ADDR_BANK_HI, BYTE_RAM_EN);
				script.entry[2] = wr(ADDR_CTRL, BYTE_ON);
				script.entry[3] = wr(ADDR_RAM_SEL, BYTE_ON);
				script.entry[4] = wr(ADDR_BANK_HI, b[BYTE_W-1:0]);
			end
			SEQ_RAM_SHORT: begin
				script.count    = 3'd2;
				script.entry[0] = wr(ADDR_CTRL, BYTE_OFF);
				script.entry[1] = wr(ADDR_BANK_HI, BYTE_RAM_EN);
			end
			default: begin
				script.status = rej;
			end
		endcase
	end

endmodule

>>> rtl/core/cbss_emit.sv
`timescale 1ns / 1ps
// Write sequencer: holds one script and issues its entries one per cycle
// into the result register while that is not stalled. Depends on cbss_pkg, cbss_if.
module cbss_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              script_valid,
	input  cbss_pkg::script_t script,
	output logic              script_take,
	cbss_res_if.source        res
);
	import cbss_pkg::*;

	logic                active_q;
	script_t             script_q;
	logic [IDX_W-1:0]    idx_q;
	logic                out_free;
	logic                step;
	logic                at_last;
	logic                fin;
	logic                res_valid_q;
	entry_t              res_entry_q;
	logic                res_last_q;
	logic [STATUS_W-1:0] res_status_q;

	assign out_free    = !res_valid_q || res.ready;
	assign step        = active_q && out_free;
	assign at_last     = (idx_q == (script_q.count - 3'd1));
	assign fin         = step && at_last;
	assign script_take = script_valid && (!active_q || fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (script_take) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (fin) begin
			active_q <= 1'b0;
		end else if (step) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (script_take) begin
			script_q <= script;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_entry_q  <= script_q.entry[idx_q];
			res_last_q   <= at_last;
			res_status_q <= script_q.status;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.write_valid = res_entry_q.write_valid;
	assign res.pak_address = res_entry_q.pak_address;
	assign res.write_byte  = res_entry_q.write_byte;
	assign res.last        = res_last_q;
	assign res.status      = res_status_q;

endmodule

>>> rtl/core/cart_bank_select_sequencer.sv
`timescale 1ns / 1ps
// Top level of the cartridge bank select sequencer: configuration registers,
// request decoder and write sequencer. Depends on cbss_pkg, cbss_if, cbss_decode, cbss_emit.
//
//   port  kind   direction  payload
//   req   valid/ready  in   mode, bank_number
//   res   valid/ready  out  write_valid, pak_address, write_byte, last, status
//   cfg   valid/ready  in   index, data (always ready)
//
// A request gives one to six results, one per cycle while the result is not stalled;
// it passes through the request register, the script register and the result
// register, and back-to-back requests follow with no gap.
// Reset clears the configuration to rom only with no ram and empties all stages.
// A stalled result holds; the request register takes the next request meanwhile.
module cart_bank_select_sequencer (
	input  logic      clk,
	input  logic      arst_n,
	cbss_req_if.sink  req,
	cbss_res_if.source res,
	cbss_cfg_if.sink  cfg
);
	import cbss_pkg::*;

	logic [MK_W-1:0] mapper_kind_q;
	logic            ram_present_q;
	logic            script_valid;
	logic            script_take;
	script_t         script;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapper_kind_q <= MK_ROM_ONLY;
			ram_present_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_MAPPER_KIND: mapper_kind_q <= cfg.data[MK_W-1:0];
				CFG_RAM_PRESENT: ram_present_q <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	cbss_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.mapper_kind  (mapper_kind_q),
		.ram_present  (ram_present_q),
		.script_valid (script_valid),
		.script       (script),
		.script_take  (script_take)
	);

	cbss_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.script_valid (script_valid),
		.script       (script),
		.script_take  (script_take),
		.res          (res)
	);

	// A rejected request is a single result that carries an error status.
	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.write_valid |-> res.last && res.status != ST_OK)
		else $error("rejected result without last or error status");

	// Every write belongs to an accepted request and reports success.
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.write_valid |-> res.status == ST_OK)
		else $error("write result with error status");

	// A script is only taken from the decoder when it holds a request.
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		script_take |-> script_valid)
		else $error("script taken without a pending request");

endmodule
